@@ design/reb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package reb_pkg;

  // item opcodes
  localparam logic [1:0] OP_PIN  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  // event codes
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_SHORT = 3'd1;
  localparam logic [2:0] EV_LONG  = 3'd2;
  localparam logic [2:0] EV_LEFT  = 3'd3;
  localparam logic [2:0] EV_RIGHT = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE   = 2'd1;
  localparam logic [1:0] REG_DETENT     = 2'd2;

  localparam logic [15:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [6:0]  DETENT_RST     = 7'd4;

  localparam int CfgDataW = 16;

  typedef struct packed {
    logic [15:0] long_press_ms;
    logic [15:0] debounce_ms;
    logic [6:0]  edges_per_detent;
  } cfg_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       pin_a;
    logic       pin_b;
    logic       pin_press;
  } item_t;

  // one saturating step up or down on the signed step count
  function automatic logic signed [7:0] sat_step(input logic signed [7:0] v,
                                                 input logic up);
    logic signed [7:0] r;
    r = v;
    if (up) begin
      if (v != 8'sh7F) r = v + 8'sd1;
    end else begin
      if (v != 8'sh80) r = v - 8'sd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/reb_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module reb_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [1:0]                      wr_index,
  input  wire logic [reb_pkg::CfgDataW-1:0]    wr_data,
  output reb_pkg::cfg_t                        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms    <= reb_pkg::LONG_PRESS_RST;
      cfg.debounce_ms      <= reb_pkg::DEBOUNCE_RST;
      cfg.edges_per_detent <= reb_pkg::DETENT_RST;
    end else if (wr_en) begin
      case (wr_index)
        reb_pkg::REG_LONG_PRESS: cfg.long_press_ms <= wr_data[15:0];
        reb_pkg::REG_DEBOUNCE:   cfg.debounce_ms   <= wr_data[15:0];
        reb_pkg::REG_DETENT:     cfg.edges_per_detent <= wr_data[6:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/reb_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module reb_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire reb_pkg::item_t item,
  input  wire reb_pkg::cfg_t  cfg,
  output logic [2:0]         ev
);

  logic              last_a, last_a_next;
  logic              last_b, last_b_next;
  logic              last_press, last_press_next;
  logic signed [7:0] step_count, step_count_next;
  logic              timer_running, timer_running_next;
  logic              press_held, press_held_next;
  logic [15:0]       held_ticks, held_ticks_next;

  logic signed [7:0] step_after_a;
  logic [6:0]        det;
  logic signed [8:0] det_pos;
  logic signed [8:0] step_wide;

  always_comb begin
    det       = (cfg.edges_per_detent == 7'd0) ? 7'd1 : cfg.edges_per_detent;
    det_pos   = $signed({2'b00, det});
    step_wide = {step_count[7], step_count};
  end

  always_comb begin
    last_a_next        = last_a;
    last_b_next        = last_b;
    last_press_next    = last_press;
    step_count_next    = step_count;
    timer_running_next = timer_running;
    press_held_next    = press_held;
    held_ticks_next    = held_ticks;
    step_after_a       = step_count;
    ev                 = reb_pkg::EV_NONE;
    case (item.opcode)
      reb_pkg::OP_PIN: begin
        // channel A first, then B, each step saturating
        if (item.pin_a != last_a) begin
          step_after_a = reb_pkg::sat_step(step_count, last_b ^ item.pin_a);
        end
        step_count_next = step_after_a;
        if (item.pin_b != last_b) begin
          step_count_next = reb_pkg::sat_step(step_after_a, ~(last_a ^ item.pin_b));
        end
        if (item.pin_press != last_press) begin
          if (item.pin_press) begin
            timer_running_next = 1'b1;
            held_ticks_next    = 16'd0;
            press_held_next    = 1'b1;
          end else begin
            press_held_next = 1'b0;
          end
        end
        last_a_next     = item.pin_a;
        last_b_next     = item.pin_b;
        last_press_next = item.pin_press;
      end
      reb_pkg::OP_TICK: begin
        if (timer_running && held_ticks != 16'hFFFF) begin
          held_ticks_next = held_ticks + 16'd1;
        end
      end
      reb_pkg::OP_POLL: begin
        if (timer_running) begin
          // rotation while a press is being timed is thrown away
          step_count_next = 8'sd0;
          if (held_ticks >= cfg.long_press_ms) begin
            ev                 = reb_pkg::EV_LONG;
            timer_running_next = 1'b0;
          end else if (!press_held) begin
            timer_running_next = 1'b0;
            if (held_ticks >= cfg.debounce_ms) ev = reb_pkg::EV_SHORT;
          end
        end else if (step_wide <= -det_pos) begin
          step_count_next = 8'sd0;
          ev              = reb_pkg::EV_LEFT;
        end else if (step_wide >= det_pos) begin
          step_count_next = 8'sd0;
          ev              = reb_pkg::EV_RIGHT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_a        <= 1'b0;
      last_b        <= 1'b0;
      last_press    <= 1'b0;
      step_count    <= 8'sd0;
      timer_running <= 1'b0;
      press_held    <= 1'b0;
      held_ticks    <= 16'd0;
    end else if (go) begin
      last_a        <= last_a_next;
      last_b        <= last_b_next;
      last_press    <= last_press_next;
      step_count    <= step_count_next;
      timer_running <= timer_running_next;
      press_held    <= press_held_next;
      held_ticks    <= held_ticks_next;
    end
  end

  // a released button always stops the timer at the next poll
  assert property (@(posedge clk) disable iff (rst)
    go && item.opcode == reb_pkg::OP_POLL && timer_running && !press_held
    |=> !timer_running)
    else $error("timer still running after poll of released button");

  // a press edge restarts the timer from zero
  assert property (@(posedge clk) disable iff (rst)
    go && item.opcode == reb_pkg::OP_PIN && item.pin_press && !last_press
    |=> timer_running && press_held && held_ticks == 16'd0)
    else $error("press edge did not restart timer");

  // any press event clears the rotation count
  assert property (@(posedge clk) disable iff (rst)
    go && (ev == reb_pkg::EV_LONG || ev == reb_pkg::EV_SHORT)
    |=> step_count == 8'sd0)
    else $error("step count not cleared on press event");

endmodule

`default_nettype wire

@@ design/rotary_encoder_button_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_ready, opcode, pin_a, pin_b, | input
//         | pin_press                                 |
// out     | out_valid, out_ready, event_code          | output
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | input
//
// one transaction per cycle on the input unless a poll stalls; each is held in
// an input register, then decoded against the state in a single pass
// a poll puts its event in the output register when it leaves the input
// register; pin samples and ticks give no output transaction
// reset clears all decoder state and loads default config (1000, 20, 4)
// only a poll waits on out_ready; while the output register is full and not
// taken, the poll holds the input register and in_ready drops
// cfg writes are taken every cycle (cfg_ready is always high)
module rotary_encoder_button_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input item transaction
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   opcode,
  input  wire logic                         pin_a,
  input  wire logic                         pin_b,
  input  wire logic                         pin_press,
  // result transaction
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [2:0]                        event_code,
  // config write transaction
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [reb_pkg::CfgDataW-1:0] cfg_data
);

  reb_pkg::cfg_t  cfg;
  reb_pkg::item_t s1_item;
  logic           s1_valid;
  logic           s1_is_poll;
  logic           out_free;
  logic           s1_go;
  logic [2:0]     ev;

  assign cfg_ready = 1'b1;

  reb_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // stage handshakes: a poll needs room in the output register
  assign s1_is_poll = (s1_item.opcode == reb_pkg::OP_POLL);
  assign out_free   = !out_valid || out_ready;
  assign s1_go      = s1_valid && (!s1_is_poll || out_free);
  assign in_ready   = !s1_valid || s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item.opcode    <= opcode;
      s1_item.pin_a     <= pin_a;
      s1_item.pin_b     <= pin_b;
      s1_item.pin_press <= pin_press;
    end
  end

  reb_core u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (s1_go),
    .item (s1_item),
    .cfg  (cfg),
    .ev   (ev)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && s1_is_poll;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_is_poll) begin
      event_code <= ev;
    end
  end

  // a poll leaving the input register always lands in the output register
  assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_is_poll |=> out_valid)
    else $error("poll result lost");

  // pin samples and ticks never stall
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_is_poll |-> s1_go)
    else $error("non-poll item stalled");

  // backpressure only comes from a stuck poll behind a full output register
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && s1_is_poll && out_valid && !out_ready)
    else $error("unexpected input stall");

  // only defined event codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_code <= reb_pkg::EV_RIGHT)
    else $error("bad event code");

endmodule

`default_nettype wire

@@ tb/tb_rotary_encoder_button_decoder.sv @@
`timescale 1ns / 1ps

module tb_rotary_encoder_button_decoder;

  // opcode 3 has no function, the block must swallow it
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int RandomItemsPerPhase = 50;
  // the pipeline has an input and an output register, leave some margin before touching config
  localparam int DrainCycles = 4;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   opcode;
  logic                         pin_a;
  logic                         pin_b;
  logic                         pin_press;
  logic                         out_valid;
  logic                         out_ready;
  logic [2:0]                   event_code;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [1:0]                   cfg_index;
  logic [reb_pkg::CfgDataW-1:0] cfg_data;

  rotary_encoder_button_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .pin_a      (pin_a),
    .pin_b      (pin_b),
    .pin_press  (pin_press),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_code (event_code),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // idle chance in percent per cycle for each side
  int tx_idle_pct;
  int rx_idle_pct;

  // decoder shadow: config copy
  logic [15:0]       long_press_cfg;
  logic [15:0]       debounce_cfg;
  logic [6:0]        detent_cfg;
  // decoder shadow: state copy
  logic              prev_a;
  logic              prev_b;
  logic              prev_press;
  logic signed [7:0] step_total;
  logic              timer_on;
  logic              button_down;
  logic [15:0]       held_count;

  // events predicted for accepted polls, oldest first
  logic [2:0] pending_events[$];

  // pin levels last driven on a pin sample
  logic cur_a;
  logic cur_b;
  logic cur_press;

  int items_sent    = 0;
  int polls_checked = 0;
  int fail_count    = 0;
  int short_seen    = 0;
  int long_seen     = 0;
  int left_seen     = 0;
  int right_seen    = 0;

  // free running clock, 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5000000;
    $display("FAIL rotary_encoder_button_decoder");
    $finish;
  end

  // result side back pressure, changes on the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  // every result transaction is matched against the oldest predicted event
  always @(posedge clk) begin : check_events
    logic [2:0] want;
    if (!rst && out_valid && out_ready) begin
      polls_checked++;
      if (pending_events.size() == 0) begin
        note_failure($sformatf("unexpected result transaction, event_code %0d", event_code));
      end else begin
        want = pending_events.pop_front();
        if (event_code !== want)
          note_failure($sformatf("event_code mismatch: expected %0d, got %0d",
                                 want, event_code));
      end
    end
  end

  // signed step count moves by one and sticks at the 8-bit limits
  function automatic logic signed [7:0] nudge_steps(input logic signed [7:0] v, input int d);
    int s;
    s = int'(v) + d;
    if (s > 127) s = 127;
    if (s < -128) s = -128;
    return s[7:0];
  endfunction

  // apply one accepted input transaction to the shadow decoder
  task automatic decode_item(input logic [1:0] op, input logic a, input logic b,
                             input logic p);
    int         det;
    logic [2:0] ev;
    ev = reb_pkg::EV_NONE;
    case (op)
      reb_pkg::OP_PIN: begin
        // quadrature rule: A first, then B, both against the old levels
        if (a != prev_a) step_total = nudge_steps(step_total, (prev_b ^ a) ? 1 : -1);
        if (b != prev_b) step_total = nudge_steps(step_total, (prev_a ^ b) ? -1 : 1);
        if (p != prev_press) begin
          if (p) begin
            // rising button edge restarts the press timer
            timer_on    = 1'b1;
            held_count  = 16'd0;
            button_down = 1'b1;
          end else begin
            button_down = 1'b0;
          end
        end
        prev_a     = a;
        prev_b     = b;
        prev_press = p;
      end
      reb_pkg::OP_TICK: begin
        if (timer_on && held_count != 16'hFFFF) held_count++;
      end
      reb_pkg::OP_POLL: begin
        if (timer_on) begin
          // rotation is thrown away while a press is being timed
          step_total = '0;
          if (held_count >= long_press_cfg) begin
            ev       = reb_pkg::EV_LONG;
            timer_on = 1'b0;
          end else if (!button_down) begin
            timer_on = 1'b0;
            if (held_count >= debounce_cfg) ev = reb_pkg::EV_SHORT;
          end
        end else begin
          // zero edges per detent acts like one, left is checked first
          det = (detent_cfg == 7'd0) ? 1 : int'(detent_cfg);
          if (int'(step_total) <= -det) begin
            step_total = '0;
            ev         = reb_pkg::EV_LEFT;
          end else if (int'(step_total) >= det) begin
            step_total = '0;
            ev         = reb_pkg::EV_RIGHT;
          end
        end
        pending_events.push_back(ev);
        case (ev)
          reb_pkg::EV_SHORT: short_seen++;
          reb_pkg::EV_LONG:  long_seen++;
          reb_pkg::EV_LEFT:  left_seen++;
          reb_pkg::EV_RIGHT: right_seen++;
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  // one input transaction: optional idle cycles, then hold valid until taken
  task automatic send_item(input logic [1:0] op, input logic a, input logic b,
                           input logic p);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    opcode    = op;
    pin_a     = a;
    pin_b     = b;
    pin_press = p;
    do @(posedge clk); while (!in_ready);
    decode_item(op, a, b, p);
    if (op != OpUnused) items_sent++;
  endtask

  task automatic drive_pins(input logic a, input logic b, input logic p);
    cur_a     = a;
    cur_b     = b;
    cur_press = p;
    send_item(reb_pkg::OP_PIN, a, b, p);
  endtask

  // gray code walk: clockwise is 00 -> 10 -> 11 -> 01
  task automatic rotate(input int n, input logic cw);
    repeat (n) begin
      if (cw) drive_pins(~cur_b, cur_a, cur_press);
      else drive_pins(cur_b, ~cur_a, cur_press);
    end
  endtask

  // pin bits on ticks and polls are don't-care, so randomize them
  task automatic tick_burst(input int n);
    repeat (n) send_item(reb_pkg::OP_TICK, rand_bit(), rand_bit(), rand_bit());
  endtask

  task automatic poll();
    send_item(reb_pkg::OP_POLL, rand_bit(), rand_bit(), rand_bit());
  endtask

  // config writes only once the block has gone quiet
  task automatic write_reg(input logic [1:0] idx,
                           input logic [reb_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      reb_pkg::REG_LONG_PRESS: long_press_cfg = data;
      reb_pkg::REG_DEBOUNCE:   debounce_cfg   = data;
      reb_pkg::REG_DETENT:     detent_cfg     = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input int long_ms, input int deb_ms, input int detent);
    write_reg(reb_pkg::REG_LONG_PRESS, long_ms[reb_pkg::CfgDataW-1:0]);
    write_reg(reb_pkg::REG_DEBOUNCE, deb_ms[reb_pkg::CfgDataW-1:0]);
    write_reg(reb_pkg::REG_DETENT, detent[reb_pkg::CfgDataW-1:0]);
  endtask

  // reset config: DETENT_RST edges make a detent, both directions
  task automatic test_reset_defaults();
    poll();
    rotate(3, 1'b1);
    poll();
    rotate(1, 1'b1);
    poll();
    // both channels flip in one sample
    drive_pins(~cur_a, ~cur_b, cur_press);
    rotate(4, 1'b0);
    poll();
  endtask

  // default debounce of 20 ticks, poll while held clears rotation
  task automatic test_button_debounce();
    drive_pins(cur_a, cur_b, 1'b1);
    tick_burst(19);
    drive_pins(cur_a, cur_b, 1'b0);
    poll();
    drive_pins(cur_a, cur_b, 1'b1);
    rotate(2, 1'b1);
    tick_burst(20);
    poll();
    drive_pins(cur_a, cur_b, 1'b0);
    poll();
  endtask

  task automatic test_press_limits();
    // zero long press time fires on the first poll after a press
    set_config(0, 20, 4);
    drive_pins(cur_a, cur_b, 1'b1);
    poll();
    poll();
    drive_pins(cur_a, cur_b, 1'b0);
    // zero debounce: an instant press and release still counts
    set_config(1, 0, 4);
    drive_pins(cur_a, cur_b, 1'b1);
    drive_pins(cur_a, cur_b, 1'b0);
    poll();
    // ticks with the timer stopped go nowhere
    tick_burst(3);
    poll();
    // widest debounce swallows the short press
    set_config(1, 65535, 4);
    drive_pins(cur_a, cur_b, 1'b1);
    drive_pins(cur_a, cur_b, 1'b0);
    // a bounce restarts the timer
    drive_pins(cur_a, cur_b, 1'b1);
    tick_burst(1);
    poll();
    drive_pins(cur_a, cur_b, 1'b0);
    poll();
  endtask

  task automatic test_detent_limits();
    // zero edges per detent behaves as one
    set_config(1000, 20, 0);
    rotate(1, 1'b1);
    poll();
    rotate(1, 1'b0);
    poll();
    set_config(1000, 20, 1);
    rotate(1, 1'b0);
    poll();
    // a wide detent, then drive the count into both saturation limits
    set_config(1000, 20, 64);
    rotate(63, 1'b1);
    poll();
    rotate(1, 1'b1);
    poll();
    rotate(130, 1'b0);
    poll();
    rotate(130, 1'b1);
    poll();
  endtask

  task automatic test_unused_opcode();
    rotate(1, 1'b1);
    send_item(OpUnused, 1'b1, 1'b1, 1'b1);
    send_item(OpUnused, 1'b0, 1'b0, 1'b0);
    poll();
  endtask

  // long press fires exactly when the tick count reaches the limit
  task automatic test_long_press_edge();
    set_config(10, 65535, 4);
    drive_pins(cur_a, cur_b, 1'b1);
    tick_burst(9);
    poll();
    tick_burst(1);
    poll();
    tick_burst(2);
    drive_pins(cur_a, cur_b, 1'b0);
    poll();
  endtask

  // mostly well formed turns and presses with random content, some noise
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int detent_hi);
    int         stop_at;
    int         kind;
    int         n;
    logic       cw;
    logic [1:0] op;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    set_config($urandom_range(1, 48), $urandom_range(0, 24), $urandom_range(1, detent_hi));
    stop_at = items_sent + RandomItemsPerPhase;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        // a turn, now and then long enough to saturate, with some jitter
        n  = ($urandom_range(9) == 0) ? $urandom_range(100, 160) : $urandom_range(1, 10);
        cw = rand_bit();
        repeat (n) begin
          if ($urandom_range(9) == 0) rotate(1, !cw);
          else rotate(1, cw);
        end
        if ($urandom_range(9) < 7) poll();
      end else if (kind < 60) begin
        // a press timed around the long press and debounce limits
        drive_pins(cur_a, cur_b, 1'b1);
        n = $urandom_range(0, int'(long_press_cfg) + 4);
        repeat (n) begin
          tick_burst(1);
          if ($urandom_range(7) == 0) poll();
          if ($urandom_range(9) == 0) rotate(1, rand_bit());
        end
        if ($urandom_range(9) < 8) drive_pins(cur_a, cur_b, 1'b0);
        poll();
      end else if (kind < 75) begin
        poll();
      end else begin
        // noise: any opcode with any pin levels
        op = 2'($urandom_range(3));
        if (op == reb_pkg::OP_PIN) drive_pins(rand_bit(), rand_bit(), rand_bit());
        else send_item(op, rand_bit(), rand_bit(), rand_bit());
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    opcode    = reb_pkg::OP_PIN;
    pin_a     = 1'b0;
    pin_b     = 1'b0;
    pin_press = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = reb_pkg::REG_LONG_PRESS;
    cfg_data  = '0;
    tx_idle_pct = 6;
    rx_idle_pct = 69;
    // shadow decoder starts from the reset state
    long_press_cfg = reb_pkg::LONG_PRESS_RST;
    debounce_cfg   = reb_pkg::DEBOUNCE_RST;
    detent_cfg     = reb_pkg::DETENT_RST;
    prev_a      = 1'b0;
    prev_b      = 1'b0;
    prev_press  = 1'b0;
    step_total  = '0;
    timer_on    = 1'b0;
    button_down = 1'b0;
    held_count  = '0;
    cur_a       = 1'b0;
    cur_b       = 1'b0;
    cur_press   = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_button_debounce();
    test_press_limits();
    test_detent_limits();
    test_unused_opcode();
    test_long_press_edge();
    // sender light and receiver heavy idling, then swapped, then none
    test_random_traffic(6, 69, 8);
    test_random_traffic(69, 6, 64);
    test_random_traffic(0, 0, 8);

    // drain the last polls, then give the pipeline time to show extras
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d input transactions and %0d polls under three idle patterns",
             items_sent, polls_checked);
    $display("events seen: %0d short, %0d long, %0d left, %0d right",
             short_seen, long_seen, left_seen, right_seen);
    if (fail_count == 0) begin
      $display("PASS rotary_encoder_button_decoder");
    end else begin
      $display("FAIL rotary_encoder_button_decoder");
    end
    $finish;
  end

endmodule
